/* rtl/core/ftrq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ftrq_pkg
// Shared types, widths, latencies and helpers of the shortest-arc rotation
// quaternion pipeline.
// ----------------------------------------------------------------------------
package ftrq_pkg;

  localparam int COORD_W   = 32;
  localparam int Q_W       = 32;
  localparam int FRAC_Q    = 30;
  localparam int MAG_W     = 30;
  localparam int TOP_LZ    = COORD_W - MAG_W;
  localparam int LZ_W      = $clog2(COORD_W) + 1;
  localparam int SUM_W     = 2 * MAG_W + 2;
  localparam int PROD_W    = 64;
  localparam int DOT_W     = 34;

  localparam int ISQ_IN_W  = 64;
  localparam int ISQ_OUT_W = ISQ_IN_W / 2;
  localparam int ISQ_REM_W = ISQ_OUT_W + 4;
  localparam int ISQ_LAT   = ISQ_IN_W / 2;

  localparam int DIV_NUM_W = 62;
  localparam int DIV_DEN_W = 32;
  localparam int DIV_Q_W   = 36;
  localparam int DIV_LAT   = DIV_Q_W;
  localparam int QUO_SW    = DIV_Q_W + 1;

  localparam int NORM_LAT  = 5 + ISQ_LAT + 1 + DIV_LAT + 1;
  localparam int SCALE_LAT = 1 + ISQ_LAT + 1 + DIV_LAT + 1;
  localparam int SC_DLY    = NORM_LAT - SCALE_LAT;
  localparam int TOP_LAT   = 2 * NORM_LAT + 4;

  localparam logic signed [PROD_W-1:0] ONE_P    = 64'sh0000_0000_4000_0000;
  localparam logic signed [DOT_W-1:0]  ONE_D    = 34'sd1073741824;
  localparam logic signed [DOT_W-1:0]  OPP_LIMIT = -34'sd1072668082;
  localparam logic signed [Q_W-1:0]    Q30_ONE  = 32'sh4000_0000;
  localparam logic signed [Q_W-1:0]    Q30_MONE = 32'shC000_0000;
  localparam logic [PROD_W-1:0]        AXIS_MIN = 64'd10737418;
  localparam logic [PROD_W-1:0]        AXIS_MIN_SQ = AXIS_MIN * AXIS_MIN;

  typedef struct packed {
    logic signed [COORD_W-1:0] from_x;
    logic signed [COORD_W-1:0] from_y;
    logic signed [COORD_W-1:0] from_z;
    logic signed [COORD_W-1:0] to_x;
    logic signed [COORD_W-1:0] to_y;
    logic signed [COORD_W-1:0] to_z;
  } in_t;

  typedef struct packed {
    logic signed [Q_W-1:0] quat_x;
    logic signed [Q_W-1:0] quat_y;
    logic signed [Q_W-1:0] quat_z;
    logic signed [Q_W-1:0] quat_w;
    logic                  opposite_case;
    logic                  zero_vector;
  } out_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vec3_t;

  typedef struct packed {
    logic  valid;
    vec3_t vec;
  } norm_in_t;

  typedef struct packed {
    logic  valid;
    logic  zero;
    vec3_t unit;
  } norm_out_t;

  typedef struct packed {
    logic                    valid;
    logic signed [DOT_W-1:0] c;
    logic signed [DOT_W-1:0] cx;
    logic signed [DOT_W-1:0] cy;
    logic signed [DOT_W-1:0] cz;
  } scale_in_t;

  typedef struct packed {
    logic                     valid;
    logic signed [QUO_SW-1:0] qx;
    logic signed [QUO_SW-1:0] qy;
    logic signed [QUO_SW-1:0] qz;
    logic [Q_W-1:0]           w;
  } scale_out_t;

  function automatic logic signed [DOT_W-1:0] shr_round30(input logic signed [PROD_W-1:0] v);
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] rnd;
    logic [DOT_W-1:0]  m;
    mag = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
    rnd = mag + (PROD_W'(1) << (FRAC_Q - 1));
    m   = rnd[PROD_W-1:FRAC_Q];
    return v[PROD_W-1] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [Q_W-1:0] sat_q30(input logic signed [QUO_SW-1:0] v);
    logic signed [Q_W-1:0] r;
    if (v > QUO_SW'(ONE_D)) begin
      r = Q30_ONE;
    end else if (v < -QUO_SW'(ONE_D)) begin
      r = Q30_MONE;
    end else begin
      r = $signed(v[Q_W-1:0]);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/ftrq_isqrt.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ftrq_isqrt
// Pipelined integer square root, one result bit per stage, floor result.
// ----------------------------------------------------------------------------
module ftrq_isqrt (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic [ftrq_pkg::ISQ_IN_W-1:0]  radicand,
  output logic                           out_valid,
  output logic [ftrq_pkg::ISQ_OUT_W-1:0] root
);
  import ftrq_pkg::*;

  typedef struct packed {
    logic [ISQ_REM_W-1:0] rem;
    logic [ISQ_OUT_W-1:0] root;
    logic [ISQ_IN_W-1:0]  rest;
  } isq_stage_t;

  function automatic isq_stage_t isq_step(input isq_stage_t s);
    isq_stage_t           n;
    logic [ISQ_REM_W-1:0] r4;
    logic [ISQ_REM_W-1:0] trial;
    r4     = {s.rem[ISQ_REM_W-3:0], s.rest[ISQ_IN_W-1 -: 2]};
    trial  = ISQ_REM_W'({s.root, 2'b01});
    n.rest = s.rest << 2;
    if (r4 >= trial) begin
      n.rem  = r4 - trial;
      n.root = {s.root[ISQ_OUT_W-2:0], 1'b1};
    end else begin
      n.rem  = r4;
      n.root = {s.root[ISQ_OUT_W-2:0], 1'b0};
    end
    return n;
  endfunction

  isq_stage_t         seed;
  isq_stage_t         st [ISQ_LAT];
  logic [ISQ_LAT-1:0] vld;

  assign seed = {ISQ_REM_W'(0), ISQ_OUT_W'(0), radicand};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[ISQ_LAT-2:0], in_valid};
    end
    st[0] <= isq_step(seed);
    for (int k = 1; k < ISQ_LAT; k++) begin
      st[k] <= isq_step(st[k-1]);
    end
  end

  assign out_valid = vld[ISQ_LAT-1];
  assign root      = st[ISQ_LAT-1].root;

endmodule
`default_nettype wire

/* rtl/core/ftrq_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ftrq_div
// Pipelined restoring divider, one quotient bit per stage. The numerator's
// upper part must be below the divisor.
// ----------------------------------------------------------------------------
module ftrq_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic [ftrq_pkg::DIV_NUM_W-1:0] numer,
  input  logic [ftrq_pkg::DIV_DEN_W-1:0] denom,
  output logic                           out_valid,
  output logic [ftrq_pkg::DIV_Q_W-1:0]   quot
);
  import ftrq_pkg::*;

  typedef struct packed {
    logic [DIV_DEN_W-1:0] rem;
    logic [DIV_DEN_W-1:0] den;
    logic [DIV_Q_W-1:0]   rest;
    logic [DIV_Q_W-1:0]   quo;
  } div_stage_t;

  function automatic div_stage_t div_step(input div_stage_t s);
    div_stage_t         n;
    logic [DIV_DEN_W:0] r;
    r      = {s.rem, s.rest[DIV_Q_W-1]};
    n.den  = s.den;
    n.rest = s.rest << 1;
    if (r >= {1'b0, s.den}) begin
      n.rem = DIV_DEN_W'(r - {1'b0, s.den});
      n.quo = {s.quo[DIV_Q_W-2:0], 1'b1};
    end else begin
      n.rem = r[DIV_DEN_W-1:0];
      n.quo = {s.quo[DIV_Q_W-2:0], 1'b0};
    end
    return n;
  endfunction

  div_stage_t         seed;
  div_stage_t         st [DIV_LAT];
  logic [DIV_LAT-1:0] vld;

  assign seed = {DIV_DEN_W'(numer[DIV_NUM_W-1:DIV_Q_W]), denom,
                 numer[DIV_Q_W-1:0], DIV_Q_W'(0)};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[DIV_LAT-2:0], in_valid};
    end
    st[0] <= div_step(seed);
    for (int k = 1; k < DIV_LAT; k++) begin
      st[k] <= div_step(st[k-1]);
    end
  end

  assign out_valid = vld[DIV_LAT-1];
  assign quot      = st[DIV_LAT-1].quo;

endmodule
`default_nettype wire

/* rtl/core/ftrq_norm.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ftrq_norm
// Normalizes a 3-D vector to a unit vector in signed 2.30 and flags a
// zero-length input.
// ----------------------------------------------------------------------------
module ftrq_norm (
  input  logic                clk,
  input  logic                rst,
  input  ftrq_pkg::norm_in_t  src,
  output ftrq_pkg::norm_out_t dst
);
  import ftrq_pkg::*;

  typedef struct packed {
    logic [2:0]            neg;
    logic                  zero;
    logic [2:0][MAG_W-1:0] m;
  } norm_side_t;

  typedef struct packed {
    logic [2:0] neg;
    logic       zero;
  } norm_sign_t;

  function automatic logic [LZ_W-1:0] lead_zeros(input logic [COORD_W-1:0] x);
    logic [LZ_W-1:0] n;
    n = LZ_W'(COORD_W);
    for (int i = 0; i < COORD_W; i++) begin
      if (x[i]) begin
        n = LZ_W'(COORD_W - 1 - i);
      end
    end
    return n;
  endfunction

  logic signed [COORD_W-1:0] v_in [3];
  logic [COORD_W-1:0]        mag [3];
  logic [COORD_W-1:0]        max01;

  logic                      f1_valid;
  logic [COORD_W-1:0]        f1_mag [3];
  logic [COORD_W-1:0]        f1_max;
  logic [2:0]                f1_neg;

  logic                      f2_valid;
  logic [COORD_W-1:0]        f2_mag [3];
  logic [LZ_W-1:0]           f2_lz;
  logic [2:0]                f2_neg;
  logic                      f2_zero;

  logic                      f3_valid;
  logic [2:0][MAG_W-1:0]     f3_m;
  logic [2:0]                f3_neg;
  logic                      f3_zero;

  logic                      f4_valid;
  logic [2*MAG_W-1:0]        f4_sq [3];
  logic                      f5_valid;
  logic [SUM_W-1:0]          f5_sum;

  norm_side_t                side [ISQ_LAT+2];
  logic                      isq_valid;
  logic [ISQ_OUT_W-1:0]      isq_root;
  logic [ISQ_OUT_W-1:0]      len;

  logic                      p_valid;
  logic [DIV_NUM_W-1:0]      p_num [3];
  logic [DIV_DEN_W-1:0]      p_den;
  norm_sign_t                p_sign;
  norm_sign_t                dsign [DIV_LAT];

  logic                      div_valid;
  logic [DIV_Q_W-1:0]        quo [3];
  logic signed [Q_W-1:0]     qs [3];

  logic                      o_valid;
  logic                      o_zero;
  vec3_t                     o_unit;

  assign v_in[0] = src.vec.x;
  assign v_in[1] = src.vec.y;
  assign v_in[2] = src.vec.z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = v_in[i][COORD_W-1] ? COORD_W'(-v_in[i]) : COORD_W'(v_in[i]);
    end
    max01 = (mag[0] > mag[1]) ? mag[0] : mag[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
      f3_valid <= 1'b0;
      f4_valid <= 1'b0;
      f5_valid <= 1'b0;
      p_valid  <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      f1_valid <= src.valid;
      f2_valid <= f1_valid;
      f3_valid <= f2_valid;
      f4_valid <= f3_valid;
      f5_valid <= f4_valid;
      p_valid  <= isq_valid;
      o_valid  <= div_valid;
    end
    for (int i = 0; i < 3; i++) begin
      f1_mag[i] <= mag[i];
      f1_neg[i] <= v_in[i][COORD_W-1];
      f2_mag[i] <= f1_mag[i];
    end
    f1_max  <= (max01 > mag[2]) ? max01 : mag[2];
    f2_lz   <= lead_zeros(f1_max);
    f2_neg  <= f1_neg;
    f2_zero <= (f1_max == '0);
    for (int i = 0; i < 3; i++) begin
      if (f2_lz < LZ_W'(TOP_LZ)) begin
        f3_m[i] <= MAG_W'(f2_mag[i] >> (LZ_W'(TOP_LZ) - f2_lz));
      end else begin
        f3_m[i] <= MAG_W'(PROD_W'(f2_mag[i]) << (f2_lz - LZ_W'(TOP_LZ)));
      end
      f4_sq[i] <= f3_m[i] * f3_m[i];
    end
    f3_neg  <= f2_neg;
    f3_zero <= f2_zero;
    f5_sum  <= SUM_W'(f4_sq[0]) + SUM_W'(f4_sq[1]) + SUM_W'(f4_sq[2]);
    side[0] <= '{neg: f3_neg, zero: f3_zero, m: f3_m};
    for (int k = 1; k < ISQ_LAT + 2; k++) begin
      side[k] <= side[k-1];
    end
    for (int i = 0; i < 3; i++) begin
      p_num[i] <= {side[ISQ_LAT+1].m[i], FRAC_Q'(0)} + DIV_NUM_W'(len >> 1);
    end
    p_den    <= len;
    p_sign   <= '{neg: side[ISQ_LAT+1].neg, zero: side[ISQ_LAT+1].zero};
    dsign[0] <= p_sign;
    for (int k = 1; k < DIV_LAT; k++) begin
      dsign[k] <= dsign[k-1];
    end
    o_zero   <= dsign[DIV_LAT-1].zero;
    o_unit.x <= dsign[DIV_LAT-1].neg[0] ? -qs[0] : qs[0];
    o_unit.y <= dsign[DIV_LAT-1].neg[1] ? -qs[1] : qs[1];
    o_unit.z <= dsign[DIV_LAT-1].neg[2] ? -qs[2] : qs[2];
  end

  assign len = (isq_root == '0) ? ISQ_OUT_W'(1) : isq_root;

  ftrq_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (f5_valid),
    .radicand (ISQ_IN_W'(f5_sum)),
    .out_valid(isq_valid),
    .root     (isq_root)
  );

  ftrq_div u_div0 (
    .clk(clk), .rst(rst), .in_valid(p_valid), .numer(p_num[0]), .denom(p_den),
    .out_valid(div_valid), .quot(quo[0])
  );
  ftrq_div u_div1 (
    .clk(clk), .rst(rst), .in_valid(p_valid), .numer(p_num[1]), .denom(p_den),
    .out_valid(), .quot(quo[1])
  );
  ftrq_div u_div2 (
    .clk(clk), .rst(rst), .in_valid(p_valid), .numer(p_num[2]), .denom(p_den),
    .out_valid(), .quot(quo[2])
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qs[i] = $signed(quo[i][Q_W-1:0]);
    end
  end

  assign dst = '{valid: o_valid, zero: o_zero, unit: o_unit};

endmodule
`default_nettype wire

/* rtl/core/ftrq_scale.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ftrq_scale
// Forms s = sqrt(2(1+c)) in 2.30, divides the cross product by s with
// rounding and gives w = s/2.
// ----------------------------------------------------------------------------
module ftrq_scale (
  input  logic                 clk,
  input  logic                 rst,
  input  ftrq_pkg::scale_in_t  src,
  output ftrq_pkg::scale_out_t dst
);
  import ftrq_pkg::*;

  typedef struct packed {
    logic [2:0]            neg;
    logic [2:0][Q_W-1:0]   mag;
  } scale_side_t;

  typedef struct packed {
    logic [2:0]     neg;
    logic [Q_W-1:0] w;
  } scale_tail_t;

  logic signed [DOT_W-1:0] cr [3];
  logic [DOT_W-1:0]        cmag [3];
  logic signed [PROD_W-1:0] e;

  logic                    s1_valid;
  logic [ISQ_IN_W-1:0]     s1_val;
  scale_side_t             s1_side;
  scale_side_t             sd [ISQ_LAT];

  logic                    isq_valid;
  logic [ISQ_OUT_W-1:0]    isq_root;
  logic [ISQ_OUT_W-1:0]    s;

  logic                    p_valid;
  logic [DIV_NUM_W-1:0]    p_num [3];
  logic [DIV_DEN_W-1:0]    p_den;
  scale_tail_t             p_tail;
  scale_tail_t             dt [DIV_LAT];

  logic                    div_valid;
  logic [DIV_Q_W-1:0]      quo [3];
  logic signed [QUO_SW-1:0] qs [3];

  logic                    o_valid;
  logic signed [QUO_SW-1:0] o_q [3];
  logic [Q_W-1:0]          o_w;

  assign cr[0] = src.cx;
  assign cr[1] = src.cy;
  assign cr[2] = src.cz;
  assign e     = PROD_W'(src.c) + ONE_P;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cmag[i] = cr[i][DOT_W-1] ? DOT_W'(-cr[i]) : DOT_W'(cr[i]);
    end
  end

  assign s = (isq_root == '0) ? ISQ_OUT_W'(1) : isq_root;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      p_valid  <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      s1_valid <= src.valid;
      p_valid  <= isq_valid;
      o_valid  <= div_valid;
    end
    s1_val <= ISQ_IN_W'(e) << (FRAC_Q + 1);
    for (int i = 0; i < 3; i++) begin
      s1_side.neg[i] <= cr[i][DOT_W-1];
      s1_side.mag[i] <= cmag[i][Q_W-1:0];
    end
    sd[0] <= s1_side;
    for (int k = 1; k < ISQ_LAT; k++) begin
      sd[k] <= sd[k-1];
    end
    for (int i = 0; i < 3; i++) begin
      p_num[i] <= {sd[ISQ_LAT-1].mag[i], FRAC_Q'(0)} + DIV_NUM_W'(s >> 1);
    end
    p_den       <= s;
    p_tail.neg  <= sd[ISQ_LAT-1].neg;
    p_tail.w    <= Q_W'((({1'b0, s}) + (ISQ_OUT_W + 1)'(1)) >> 1);
    dt[0]       <= p_tail;
    for (int k = 1; k < DIV_LAT; k++) begin
      dt[k] <= dt[k-1];
    end
    for (int i = 0; i < 3; i++) begin
      o_q[i] <= dt[DIV_LAT-1].neg[i] ? -qs[i] : qs[i];
    end
    o_w <= dt[DIV_LAT-1].w;
  end

  ftrq_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s1_valid),
    .radicand (s1_val),
    .out_valid(isq_valid),
    .root     (isq_root)
  );

  ftrq_div u_div0 (
    .clk(clk), .rst(rst), .in_valid(p_valid), .numer(p_num[0]), .denom(p_den),
    .out_valid(div_valid), .quot(quo[0])
  );
  ftrq_div u_div1 (
    .clk(clk), .rst(rst), .in_valid(p_valid), .numer(p_num[1]), .denom(p_den),
    .out_valid(), .quot(quo[1])
  );
  ftrq_div u_div2 (
    .clk(clk), .rst(rst), .in_valid(p_valid), .numer(p_num[2]), .denom(p_den),
    .out_valid(), .quot(quo[2])
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qs[i] = $signed({1'b0, quo[i]});
    end
  end

  assign dst = '{valid: o_valid, qx: o_q[0], qy: o_q[1], qz: o_q[2], w: o_w};

endmodule
`default_nettype wire

/* rtl/core/from_to_rotation_quaternion_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// from_to_rotation_quaternion_unit
// Shortest-arc unit quaternion between two 16.16 direction vectors.
// ----------------------------------------------------------------------------
// The unit is a fully pipelined datapath: it takes one request in every clock
// cycle (busy stays low) and delivers each result exactly 154 cycles after its
// start, in request order, as a one-cycle result_valid strobe that the
// receiver must take. The latency is set by two vector normalizers in series,
// each 75 stages long (five stages of magnitude scaling and squaring, a
// 32-stage square root, one stage of divider setup, a 36-stage divider and one
// stage of sign restore), plus four stages of dot, cross and output logic.
module from_to_rotation_quaternion_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  ftrq_pkg::in_t  request,
  output logic           result_valid,
  output ftrq_pkg::out_t result
);
  import ftrq_pkg::*;

  typedef struct packed {
    logic opp;
    logic small_axis;
    logic zero;
  } top_side_t;

  norm_in_t                nf_in;
  norm_in_t                nt_in;
  norm_out_t               nf_out;
  norm_out_t               nt_out;
  norm_in_t                na_in;
  norm_out_t               na_out;
  vec3_t                   f;
  vec3_t                   t;

  logic                    p1_valid;
  logic                    p1_zero;
  logic signed [PROD_W-1:0] p1_dot [3];
  logic signed [PROD_W-1:0] p1_cr [6];
  logic signed [PROD_W-1:0] p1_ss [2];
  logic signed [COORD_W-1:0] p1_f0;
  logic signed [COORD_W-1:0] p1_f1;

  logic                    p2_valid;
  logic                    p2_zero;
  logic signed [PROD_W-1:0] p2_dot;
  logic signed [PROD_W-1:0] p2_cr [3];
  logic [PROD_W-1:0]       p2_ss;
  logic signed [COORD_W-1:0] p2_f0;
  logic signed [COORD_W-1:0] p2_f1;

  logic signed [DOT_W-1:0] c_raw;
  logic signed [DOT_W-1:0] c_clamp;

  logic                    p3_valid;
  scale_in_t               p3_sc;
  top_side_t               p3_side;
  logic signed [COORD_W-1:0] p3_f0;
  logic signed [COORD_W-1:0] p3_f1;

  scale_in_t               sc_dly [SC_DLY];
  scale_out_t              sc_out;
  top_side_t               side [NORM_LAT];
  top_side_t               fin;

  out_t                    res_next;
  out_t                    res;
  logic                    res_valid;

  assign busy = 1'b0;

  assign nf_in = '{valid: start & ~busy,
                   vec: '{x: request.from_x, y: request.from_y, z: request.from_z}};
  assign nt_in = '{valid: start & ~busy,
                   vec: '{x: request.to_x, y: request.to_y, z: request.to_z}};

  ftrq_norm u_norm_from (.clk(clk), .rst(rst), .src(nf_in), .dst(nf_out));
  ftrq_norm u_norm_to   (.clk(clk), .rst(rst), .src(nt_in), .dst(nt_out));

  assign f = nf_out.unit;
  assign t = nt_out.unit;

  assign c_raw   = shr_round30(p2_dot);
  assign c_clamp = (c_raw > ONE_D) ? ONE_D : c_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
      for (int k = 0; k < SC_DLY; k++) begin
        sc_dly[k] <= '0;
      end
      res_valid <= 1'b0;
    end else begin
      p1_valid  <= nf_out.valid;
      p2_valid  <= p1_valid;
      p3_valid  <= p2_valid;
      sc_dly[0] <= p3_sc;
      for (int k = 1; k < SC_DLY; k++) begin
        sc_dly[k] <= sc_dly[k-1];
      end
      res_valid <= na_out.valid;
    end
    p1_zero   <= nf_out.zero | nt_out.zero;
    p1_dot[0] <= PROD_W'($signed(f.x)) * PROD_W'($signed(t.x));
    p1_dot[1] <= PROD_W'($signed(f.y)) * PROD_W'($signed(t.y));
    p1_dot[2] <= PROD_W'($signed(f.z)) * PROD_W'($signed(t.z));
    p1_cr[0]  <= PROD_W'($signed(f.y)) * PROD_W'($signed(t.z));
    p1_cr[1]  <= PROD_W'($signed(f.z)) * PROD_W'($signed(t.y));
    p1_cr[2]  <= PROD_W'($signed(f.z)) * PROD_W'($signed(t.x));
    p1_cr[3]  <= PROD_W'($signed(f.x)) * PROD_W'($signed(t.z));
    p1_cr[4]  <= PROD_W'($signed(f.x)) * PROD_W'($signed(t.y));
    p1_cr[5]  <= PROD_W'($signed(f.y)) * PROD_W'($signed(t.x));
    p1_ss[0]  <= PROD_W'($signed(f.x)) * PROD_W'($signed(f.x));
    p1_ss[1]  <= PROD_W'($signed(f.y)) * PROD_W'($signed(f.y));
    p1_f0     <= f.x;
    p1_f1     <= f.y;

    p2_zero  <= p1_zero;
    p2_dot   <= p1_dot[0] + p1_dot[1] + p1_dot[2];
    p2_cr[0] <= p1_cr[0] - p1_cr[1];
    p2_cr[1] <= p1_cr[2] - p1_cr[3];
    p2_cr[2] <= p1_cr[4] - p1_cr[5];
    p2_ss    <= PROD_W'(p1_ss[0]) + PROD_W'(p1_ss[1]);
    p2_f0    <= p1_f0;
    p2_f1    <= p1_f1;

    p3_sc.valid        <= p2_valid;
    p3_sc.c            <= c_clamp;
    p3_sc.cx           <= shr_round30(p2_cr[0]);
    p3_sc.cy           <= shr_round30(p2_cr[1]);
    p3_sc.cz           <= shr_round30(p2_cr[2]);
    p3_side.opp        <= (c_clamp < OPP_LIMIT);
    p3_side.small_axis <= (p2_ss < AXIS_MIN_SQ);
    p3_side.zero       <= p2_zero;
    p3_f0              <= p2_f0;
    p3_f1              <= p2_f1;

    side[0] <= p3_side;
    for (int k = 1; k < NORM_LAT; k++) begin
      side[k] <= side[k-1];
    end
    res <= res_next;
  end

  assign na_in = '{valid: p3_valid, vec: '{x: -p3_f1, y: p3_f0, z: '0}};

  ftrq_norm  u_norm_axis (.clk(clk), .rst(rst), .src(na_in), .dst(na_out));
  ftrq_scale u_scale (.clk(clk), .rst(rst), .src(sc_dly[SC_DLY-1]), .dst(sc_out));

  assign fin = side[NORM_LAT-1];

  always_comb begin
    res_next = '0;
    if (fin.zero) begin
      res_next.quat_w      = Q30_ONE;
      res_next.zero_vector = 1'b1;
    end else if (fin.opp) begin
      res_next.opposite_case = 1'b1;
      if (fin.small_axis || na_out.zero) begin
        res_next.quat_x = Q30_ONE;
      end else begin
        res_next.quat_x = na_out.unit.x;
        res_next.quat_y = na_out.unit.y;
        res_next.quat_z = na_out.unit.z;
      end
    end else begin
      res_next.quat_x = sat_q30(sc_out.qx);
      res_next.quat_y = sat_q30(sc_out.qy);
      res_next.quat_z = sat_q30(sc_out.qz);
      res_next.quat_w = sat_q30(QUO_SW'(sc_out.w));
    end
  end

  assign result_valid = res_valid;
  assign result       = res;

  a_latency : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##TOP_LAT result_valid)
    else $error("request did not produce a result at the pipeline latency");

  a_no_orphan : assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(start, TOP_LAT))
    else $error("result strobe without a matching request");

  a_zero_ident : assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.zero_vector) |->
      (result.quat_w == Q30_ONE && result.quat_x == 0 && !result.opposite_case))
    else $error("zero-length request did not give the identity");

  a_opp_w : assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.opposite_case) |-> (result.quat_w == 0))
    else $error("half-turn result with nonzero w");

endmodule
`default_nettype wire
